FILE: rtl/scpd_pkg.sv
`default_nettype none
package scpd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 4'd1;

  // Reset values of the sync registers
  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'h81;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'hA1;

  // Controller -> datapath commands
  typedef struct packed {
    logic store;       // write the accepted word into the payload store and sums
    logic clear;       // clear sums and byte count
    logic start_emit;  // rewind the readout pointer
    logic emit_en;     // readout of the payload store is running
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic sync1_hit;
    logic sync2_hit;
    logic data_last;
    logic ck0_hit;
    logic ck1_hit;
    logic emit_done;
  } stat_t;

endpackage
`default_nettype wire

FILE: rtl/scpd_if.sv
`default_nettype none
// Received byte channel
interface scpd_rx_if;
  logic                          valid;
  logic                          ready;
  logic [scpd_pkg::BYTE_W-1:0]   rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Payload output channel
interface scpd_pl_if;
  logic                          valid;
  logic                          ready;
  logic [scpd_pkg::BYTE_W-1:0]   payload_byte;
  logic                          payload_last;
  modport source (output valid, output payload_byte, output payload_last, input ready);
  modport sink   (input valid, input payload_byte, input payload_last, output ready);
endinterface

// Configuration write channel
interface scpd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [scpd_pkg::CFG_IDX_W-1:0]  index;
  logic [scpd_pkg::BYTE_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/scpd_ctrl.sv
`default_nettype none
module scpd_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            rx_valid_i,
  output logic                 rx_ready_o,
  input  wire scpd_pkg::stat_t stat_i,
  output scpd_pkg::cmd_t       cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SYNC2 = 3'd1;
  localparam logic [2:0] ST_DATA  = 3'd2;
  localparam logic [2:0] ST_CK0   = 3'd3;
  localparam logic [2:0] ST_CK1   = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       acc;

  // No words taken while the payload store is read out
  assign rx_ready_o = (state_q != ST_EMIT);
  assign acc        = rx_valid_i && rx_ready_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (acc && stat_i.sync1_hit) state_d = ST_SYNC2;
      end
      ST_SYNC2: begin
        if (acc) begin
          cmd_o.clear = 1'b1;
          state_d     = stat_i.sync2_hit ? ST_DATA : ST_IDLE;
        end
      end
      ST_DATA: begin
        if (acc) begin
          cmd_o.store = 1'b1;
          if (stat_i.data_last) state_d = ST_CK0;
        end
      end
      ST_CK0: begin
        if (acc) state_d = stat_i.ck0_hit ? ST_CK1 : ST_IDLE;
      end
      ST_CK1: begin
        if (acc) begin
          if (stat_i.ck1_hit) begin
            cmd_o.start_emit = 1'b1;
            state_d          = ST_EMIT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        cmd_o.emit_en = 1'b1;
        if (stat_i.emit_done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Readout only follows a frame whose second checksum word matched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && $past(state_q) != ST_EMIT) |-> $past(stat_i.ck1_hit && acc))
    else $error("readout started without a checksum match");

endmodule
`default_nettype wire

FILE: rtl/scpd_dp.sv
`default_nettype none
module scpd_dp #(
  parameter int unsigned PAYLOAD_LEN = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [scpd_pkg::BYTE_W-1:0]   rx_byte_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [scpd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [scpd_pkg::BYTE_W-1:0]   cfg_data_i,
  input  wire scpd_pkg::cmd_t                cmd_i,
  output scpd_pkg::stat_t                    stat_o,
  output logic                               pl_valid_o,
  input  wire logic                          pl_ready_i,
  output logic [scpd_pkg::BYTE_W-1:0]        pl_byte_o,
  output logic                               pl_last_o
);

  localparam int unsigned AW = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;
  localparam int unsigned CW = $clog2(PAYLOAD_LEN + 1);
  localparam logic [CW-1:0] CNT_LEN  = CW'(PAYLOAD_LEN);
  localparam logic [CW-1:0] CNT_LAST = CW'(PAYLOAD_LEN - 1);

  logic [scpd_pkg::BYTE_W-1:0] sync_first_q, sync_second_q;
  logic [scpd_pkg::BYTE_W-1:0] sum_low_q, sum_low_d, sum_high_q, sum_high_d;
  logic [CW-1:0]               wr_cnt_q, wr_cnt_d;
  logic [CW-1:0]               rd_cnt_q, rd_cnt_d;
  logic                        out_valid_q, out_valid_d;
  logic                        out_last_q;
  logic [scpd_pkg::BYTE_W-1:0] out_byte_q;
  logic                        advance, issue;
  logic [scpd_pkg::BYTE_W-1:0] store_mem [PAYLOAD_LEN];

  // Sync registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= scpd_pkg::SYNC_FIRST_RST;
      sync_second_q <= scpd_pkg::SYNC_SECOND_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == scpd_pkg::REG_SYNC_FIRST)  sync_first_q  <= cfg_data_i;
      if (cfg_index_i == scpd_pkg::REG_SYNC_SECOND) sync_second_q <= cfg_data_i;
    end
  end

  // Running sums and write count
  always_comb begin
    sum_low_d  = sum_low_q;
    sum_high_d = sum_high_q;
    wr_cnt_d   = wr_cnt_q;
    if (cmd_i.clear) begin
      sum_low_d  = '0;
      sum_high_d = '0;
      wr_cnt_d   = '0;
    end else if (cmd_i.store) begin
      sum_low_d  = sum_low_q + rx_byte_i;
      sum_high_d = sum_high_q + sum_low_d;
      wr_cnt_d   = wr_cnt_q + CW'(1);
    end
  end

  // Readout: output register loads when empty or taken
  assign advance     = !out_valid_q || pl_ready_i;
  assign issue       = advance && cmd_i.emit_en && (rd_cnt_q != CNT_LEN);
  assign out_valid_d = advance ? issue : out_valid_q;

  always_comb begin
    rd_cnt_d = rd_cnt_q;
    if (cmd_i.start_emit) rd_cnt_d = '0;
    else if (issue)       rd_cnt_d = rd_cnt_q + CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_low_q   <= '0;
      sum_high_q  <= '0;
      wr_cnt_q    <= '0;
      rd_cnt_q    <= CNT_LEN;
      out_valid_q <= 1'b0;
    end else begin
      sum_low_q   <= sum_low_d;
      sum_high_q  <= sum_high_d;
      wr_cnt_q    <= wr_cnt_d;
      rd_cnt_q    <= rd_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload store, registered read straight into the output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) store_mem[wr_cnt_q[AW-1:0]] <= rx_byte_i;
    if (issue) begin
      out_byte_q <= store_mem[rd_cnt_q[AW-1:0]];
      out_last_q <= (rd_cnt_q == CNT_LAST);
    end
  end

  // Status
  assign stat_o.sync1_hit = (rx_byte_i == sync_first_q);
  assign stat_o.sync2_hit = (rx_byte_i == sync_second_q);
  assign stat_o.data_last = (wr_cnt_q == CNT_LAST);
  assign stat_o.ck0_hit   = (rx_byte_i == sum_low_q);
  assign stat_o.ck1_hit   = (rx_byte_i == sum_high_q);
  assign stat_o.emit_done = (rd_cnt_q == CNT_LEN);

  assign pl_valid_o = out_valid_q;
  assign pl_byte_o  = out_byte_q;
  assign pl_last_o  = out_last_q;

  // Store is never written while it is being read out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.store && cmd_i.emit_en))
    else $error("payload store written during readout");

  // Pointers stay within the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_cnt_q <= CNT_LEN) && (wr_cnt_q <= CNT_LEN))
    else $error("store pointer out of range");

  // A readout word is only issued into a free or drained output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pl_ready_i) |=> $stable(out_byte_q) && $stable(out_last_q))
    else $error("output word overwritten under stall");

endmodule
`default_nettype wire

FILE: rtl/sync_checksum_packet_deframer.sv
`default_nettype none
// Sync/checksum packet deframer.
// rx_i takes one received word per accepted handshake. The block hunts for the
// sync_first word, then requires sync_second, stores PAYLOAD_LEN payload words
// while keeping two wrapping 8-bit sums, and compares two checksum words.
// On a match the stored payload leaves on pl_o in order, payload_last on the
// final word; a mismatch drops the frame without output.
// cfg_i writes register 0 (sync_first) or 1 (sync_second); it is always ready.
// Throughput: one rx word per cycle while parsing. After a good frame rx_i
// ready stays low while the store is read out, one word a cycle while the
// receiver is ready, through the single read port of the payload store into
// the output register; the readout pointer is rewound as the second checksum
// word is accepted, then the first payload word is registered. A stalled
// receiver holds the output register and stretches the readout; the last word
// may wait in the output register while the next frame is already taken.
// Reset returns the parser to hunting, clears the sums and loads the sync
// registers with 0x81 and 0xA1; the payload store is not cleared.
module sync_checksum_packet_deframer #(
  parameter int unsigned PAYLOAD_LEN = 32
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  scpd_rx_if.sink     rx_i,
  scpd_pl_if.source   pl_o,
  scpd_cfg_if.sink    cfg_i
);

  scpd_pkg::cmd_t  cmd;
  scpd_pkg::stat_t stat;
  logic            rx_ready;

  assign rx_i.ready  = rx_ready;
  assign cfg_i.ready = 1'b1;

  scpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_i.valid),
    .rx_ready_o (rx_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  scpd_dp #(
    .PAYLOAD_LEN (PAYLOAD_LEN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_byte_i   (rx_i.rx_byte),
    .cfg_we_i    (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .pl_valid_o  (pl_o.valid),
    .pl_ready_i  (pl_o.ready),
    .pl_byte_o   (pl_o.payload_byte),
    .pl_last_o   (pl_o.payload_last)
  );

endmodule
`default_nettype wire
